/* hdl/ctss_pkg.sv */
// Package for the convolution tile size search unit.
// Field widths, limits, status codes and stream packing constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctss_pkg;

  localparam int unsigned ChW     = 13;
  localparam int unsigned SpW     = 11;
  localparam int unsigned KW      = 4;
  localparam int unsigned LimW    = 16;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 40;

  localparam logic [ChW-1:0] MaxChannels = 13'd4096;
  localparam logic [SpW-1:0] MaxSpatial  = 11'd1024;
  localparam logic [ChW-1:0] OutGroup    = 13'd16;

  localparam logic [15:0] Recip3 = 16'hAAAB;  // x/3 == (x*Recip3)>>17 for 16-bit x
  localparam logic [15:0] Recip5 = 16'hCCCD;  // x/5 == (x*Recip5)>>18 for 16-bit x

  localparam logic [LimW-1:0] WeightLimitRst = 16'd256;
  localparam logic [LimW-1:0] InputLimitRst  = 16'd1024;
  localparam logic [LimW-1:0] OutputLimitRst = 16'd2048;

  localparam logic [1:0] RegWeightLimit = 2'd0;
  localparam logic [1:0] RegInputLimit  = 2'd1;
  localparam logic [1:0] RegOutputLimit = 2'd2;

  localparam logic [1:0] StFit     = 2'd0;
  localparam logic [1:0] StWeight  = 2'd1;
  localparam logic [1:0] StSpatial = 2'd2;

endpackage

`default_nettype wire

/* hdl/conv_tile_size_search_unit.sv */
// Convolution tile size search: top level and sequencer.
// One shared multiplier runs the depth checks and the shrink/enlarge steps.
// Depends on ctss_pkg.
//
// Usage: one layer shape enters on the s_axis channel (tvalid/tready); one
// result leaves on the m_axis channel. The three depth limits are written
// through cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle.
// The block handles one layer at a time: s_axis_tready is high only when
// no search is running and no result is waiting.
// The setup states S_H1 to S_H4 compute the halo and the weight depth
// constant. Each depth check then walks S = ceil(out_channels / tile_out_ch)
// output channel strips, one per cycle, before it compares the depths.
// Each shrink step and each enlarge candidate is followed by a new check.
// Enlarge candidates scale tile_rows by 2, 3 and so on while the result
// stays within rows.
// Reset clears the sequencer and loads the default limits (256, 1024, 2048).
// A result holds on m_axis until taken; a stalled receiver stalls the block.
`timescale 1ns / 1ps
`default_nettype none

module conv_tile_size_search_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [1:0]                         cfg_idx_i,
  input  wire logic [ctss_pkg::LimW-1:0]          cfg_data_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [12:0] in_channels, [25:13] out_channels, [36:26] rows, [47:37] cols,
  // [51:48] kernel, [55:52] stride, [59:56] dilation, [63:60] zero
  input  wire logic [ctss_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [12:0] tile_out_ch, [23:13] tile_rows, [34:24] tile_cols,
  // [36:35] fit_status, [39:37] zero
  output logic [ctss_pkg::OutDataW-1:0]           m_axis_tdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_H1, S_H2, S_H3, S_H4,
    S_C_GOUT, S_C_RE, S_C_CE, S_C_RC, S_C_G, S_C_GD, S_C_O1, S_C_O2, S_C_W,
    S_SH_DEC, S_SH_M1, S_SH_M2, S_SH_APPLY,
    S_EN_MUL, S_EN_CMP, S_EN_DEC, S_DONE
  } state_e;

  typedef enum logic [1:0] {OP_TM, OP_TR, OP_TC} op_e;

  typedef enum logic [1:0] {F_NONE, F_WEIGHT, F_INPUT, F_OUTPUT} fault_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [ctss_pkg::LimW-1:0] wlim_q, ilim_q, olim_q;

  logic [12:0] m_q, m_d, tm_q, tm_d;
  logic [10:0] r_q, r_d, tr_q, tr_d, tc_q, tc_d, chk_tr_q, chk_tr_d, scale_q, scale_d;
  logic [3:0]  k_q, k_d, s_q, s_d, d_q, d_d;
  logic [7:0]  gin_q, gin_d, halo_q, halo_d;
  logic [14:0] wconst_q, wconst_d;
  logic [12:0] start_q, start_d, q3_q, q3_d;
  logic [8:0]  gmax_q, gmax_d;
  logic [13:0] re_q, re_d;
  logic [35:0] gd_q, gd_d;
  logic [30:0] od_q, od_d;
  fault_e      f_q, f_d;
  logic        ret_en_q, ret_en_d;
  logic [1:0]  status_q, status_d;
  logic        ovalid_q, ovalid_d;

  logic [27:0] mul_a;
  logic [15:0] mul_b;
  logic [43:0] prod_q;

  // Field extraction with saturation.
  logic [12:0] in_n, in_m;
  logic [10:0] in_r, in_c;
  logic [3:0]  in_k, in_s, in_d;
  logic [12:0] raw_n, raw_m;
  logic [10:0] raw_r, raw_c;

  assign raw_n = s_axis_tdata[12:0];
  assign raw_m = s_axis_tdata[25:13];
  assign raw_r = s_axis_tdata[36:26];
  assign raw_c = s_axis_tdata[47:37];

  always_comb begin
    in_n = (raw_n == 13'd0) ? 13'd1 :
           (raw_n > ctss_pkg::MaxChannels) ? ctss_pkg::MaxChannels : raw_n;
    in_m = (raw_m == 13'd0) ? 13'd1 :
           (raw_m > ctss_pkg::MaxChannels) ? ctss_pkg::MaxChannels : raw_m;
    in_r = (raw_r == 11'd0) ? 11'd1 :
           (raw_r > ctss_pkg::MaxSpatial) ? ctss_pkg::MaxSpatial : raw_r;
    in_c = (raw_c == 11'd0) ? 11'd1 :
           (raw_c > ctss_pkg::MaxSpatial) ? ctss_pkg::MaxSpatial : raw_c;
    in_k = (s_axis_tdata[51:48] == 4'd0) ? 4'd1 : s_axis_tdata[51:48];
    in_s = (s_axis_tdata[55:52] == 4'd0) ? 4'd1 : s_axis_tdata[55:52];
    in_d = (s_axis_tdata[59:56] == 4'd0) ? 4'd1 : s_axis_tdata[59:56];
  end

  // Shared-unit helpers.
  logic [12:0] opv;
  logic [13:0] ce_w;
  logic [13:0] strip_end;
  logic [14:0] t_w;
  logic [12:0] q5_w, q3x3, nv_w;
  logic [15:0] q5x5;

  always_comb begin
    case (op_q)
      OP_TR:   opv = {2'b0, tr_q};
      OP_TC:   opv = {2'b0, tc_q};
      default: opv = tm_q;
    endcase
    ce_w      = prod_q[13:0] + {6'b0, halo_q};
    strip_end = {1'b0, start_q} + {1'b0, tm_q};
    t_w       = ({1'b0, strip_end} + 15'd15) >> 4;
    t_w       = t_w - {6'b0, start_q[12:4]};
    q5_w      = prod_q[30:18];
    q3x3      = {q3_q[11:0], 1'b0} + q3_q;
    q5x5      = {1'b0, q5_w, 2'b0} + {3'b0, q5_w};
  end

  // Shared multiplier operand select; product registered every cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_H1:     begin mul_a = {24'b0, k_q - 4'd1};     mul_b = {12'b0, d_q};    end
      S_H2:     begin mul_a = {24'b0, k_q};            mul_b = {12'b0, k_q};    end
      S_H3:     begin mul_a = {20'b0, prod_q[7:0]};    mul_b = {8'b0, gin_q};   end
      S_C_RE:   begin mul_a = {17'b0, chk_tr_q - 11'd1}; mul_b = {12'b0, s_q};  end
      S_C_CE:   begin mul_a = {17'b0, tc_q - 11'd1};   mul_b = {12'b0, s_q};    end
      S_C_RC:   begin mul_a = {14'b0, re_q};           mul_b = {2'b0, ce_w};    end
      S_C_G:    begin mul_a = prod_q[27:0];            mul_b = {8'b0, gin_q};   end
      S_C_GD:   begin mul_a = {17'b0, chk_tr_q};       mul_b = {5'b0, tc_q};    end
      S_C_O1:   begin mul_a = {6'b0, prod_q[21:0]};    mul_b = {7'b0, gmax_q};  end
      S_C_O2:   begin mul_a = {13'b0, wconst_q};       mul_b = {7'b0, gmax_q};  end
      S_SH_M1:  begin mul_a = {15'b0, opv};            mul_b = ctss_pkg::Recip3; end
      S_SH_M2:  begin mul_a = {15'b0, opv};            mul_b = ctss_pkg::Recip5; end
      S_EN_MUL: begin mul_a = {17'b0, scale_q};        mul_b = {5'b0, tr_q};    end
      default:  begin mul_a = '0;                      mul_b = '0;              end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {16'b0, mul_a} * {28'b0, mul_b};
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b0, status_q, tc_q, tr_q, tm_q};

  always_comb begin
    state_d  = state_q;   op_d     = op_q;
    m_d = m_q; r_d = r_q; k_d = k_q; s_d = s_q; d_d = d_q;
    tm_d = tm_q; tr_d = tr_q; tc_d = tc_q; chk_tr_d = chk_tr_q; scale_d = scale_q;
    gin_d = gin_q; halo_d = halo_q; wconst_d = wconst_q;
    start_d = start_q; gmax_d = gmax_q; q3_d = q3_q;
    re_d = re_q; gd_d = gd_q; od_d = od_q; f_d = f_q;
    ret_en_d = ret_en_q; status_d = status_q; ovalid_d = ovalid_q;
    nv_w = '0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          m_d = in_m; r_d = in_r; k_d = in_k; s_d = in_s; d_d = in_d;
          tm_d = in_m; tr_d = in_r; tc_d = in_c;
          gin_d = 8'((({1'b0, in_n} + 14'd31) >> 5));
          status_d = ctss_pkg::StFit;
          state_d = S_H1;
        end
      end
      S_H1: state_d = S_H2;
      S_H2: begin
        halo_d  = prod_q[7:0] + 8'd1;
        state_d = S_H3;
      end
      S_H3: state_d = S_H4;
      S_H4: begin
        wconst_d = prod_q[14:0];
        chk_tr_d = tr_q;
        ret_en_d = 1'b0;
        start_d  = '0;
        gmax_d   = '0;
        state_d  = S_C_GOUT;
      end
      // walk the output channel strips, one per cycle
      S_C_GOUT: begin
        if (t_w[8:0] > gmax_d) gmax_d = t_w[8:0];
        if (strip_end >= {1'b0, m_q}) state_d = S_C_RE;
        else start_d = strip_end[12:0];
      end
      S_C_RE: state_d = S_C_CE;
      S_C_CE: begin
        re_d    = prod_q[13:0] + {6'b0, halo_q};
        state_d = S_C_RC;
      end
      S_C_RC: state_d = S_C_G;
      S_C_G:  state_d = S_C_GD;
      S_C_GD: begin
        gd_d    = prod_q[35:0];
        state_d = S_C_O1;
      end
      S_C_O1: state_d = S_C_O2;
      S_C_O2: begin
        od_d    = prod_q[30:0];
        state_d = S_C_W;
      end
      S_C_W: begin
        if (prod_q[23:0] >= {8'b0, wlim_q})      f_d = F_WEIGHT;
        else if (gd_q >= {20'b0, ilim_q})        f_d = F_INPUT;
        else if (od_q >= {15'b0, olim_q})        f_d = F_OUTPUT;
        else                                     f_d = F_NONE;
        state_d = ret_en_q ? S_EN_DEC : S_SH_DEC;
      end
      S_SH_DEC: begin
        if (f_q == F_NONE) begin
          scale_d = 11'd2;
          state_d = S_EN_MUL;
        end else if (f_q == F_WEIGHT) begin
          op_d = OP_TM; state_d = S_SH_M1;
        end else if (tr_q != 11'd1) begin
          op_d = OP_TR; state_d = S_SH_M1;
        end else if (tc_q != 11'd1) begin
          op_d = OP_TC; state_d = S_SH_M1;
        end else begin
          status_d = ctss_pkg::StSpatial;
          ovalid_d = 1'b1;
          state_d  = S_DONE;
        end
      end
      S_SH_M1: state_d = S_SH_M2;
      S_SH_M2: begin
        q3_d    = prod_q[29:17];
        state_d = S_SH_APPLY;
      end
      S_SH_APPLY: begin
        start_d  = '0;
        gmax_d   = '0;
        ret_en_d = 1'b0;
        if (op_q == OP_TM) begin
          if (!opv[0])                        nv_w = opv >> 1;
          else if (q3x3 == opv)               nv_w = q3_q;
          else if (q5x5 == {3'b0, opv})       nv_w = q5_w;
          else                                nv_w = ctss_pkg::OutGroup;
          if (nv_w < ctss_pkg::OutGroup) nv_w = ctss_pkg::OutGroup;
          if (nv_w == tm_q) begin
            status_d = ctss_pkg::StWeight;
            ovalid_d = 1'b1;
            state_d  = S_DONE;
          end else begin
            tm_d     = nv_w;
            chk_tr_d = tr_q;
            state_d  = S_C_GOUT;
          end
        end else begin
          if (!opv[0])            nv_w = opv >> 1;
          else if (q3x3 == opv)   nv_w = q3_q;
          else                    nv_w = 13'd1;
          if (op_q == OP_TR) begin
            tr_d     = nv_w[10:0];
            chk_tr_d = nv_w[10:0];
          end else begin
            tc_d     = nv_w[10:0];
            chk_tr_d = tr_q;
          end
          if (tm_q < ctss_pkg::OutGroup) tm_d = ctss_pkg::OutGroup;
          state_d = S_C_GOUT;
        end
      end
      S_EN_MUL: state_d = S_EN_CMP;
      S_EN_CMP: begin
        if (prod_q[21:0] > {11'b0, r_q}) begin
          ovalid_d = 1'b1;
          state_d  = S_DONE;
        end else begin
          chk_tr_d = prod_q[10:0];
          ret_en_d = 1'b1;
          start_d  = '0;
          gmax_d   = '0;
          state_d  = S_C_GOUT;
        end
      end
      S_EN_DEC: begin
        if (f_q == F_NONE) tr_d = chk_tr_q;
        scale_d = scale_q + 11'd1;
        state_d = S_EN_MUL;
      end
      S_DONE: begin
        if (m_axis_tready) begin
          ovalid_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      wlim_q   <= ctss_pkg::WeightLimitRst;
      ilim_q   <= ctss_pkg::InputLimitRst;
      olim_q   <= ctss_pkg::OutputLimitRst;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ctss_pkg::RegWeightLimit: wlim_q <= cfg_data_i;
          ctss_pkg::RegInputLimit:  ilim_q <= cfg_data_i;
          ctss_pkg::RegOutputLimit: olim_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    m_q <= m_d; r_q <= r_d; k_q <= k_d; s_q <= s_d; d_q <= d_d;
    tm_q <= tm_d; tr_q <= tr_d; tc_q <= tc_d; chk_tr_q <= chk_tr_d; scale_q <= scale_d;
    gin_q <= gin_d; halo_q <= halo_d; wconst_q <= wconst_d;
    start_q <= start_d; gmax_q <= gmax_d; q3_q <= q3_d;
    re_q <= re_d; gd_q <= gd_d; od_q <= od_d; f_q <= f_d;
    ret_en_q <= ret_en_d; status_q <= status_d;
  end

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Testbench for the convolution tile size search unit.
// Predicts each layer's tile sizes and status and checks every result transfer in order.
// Depends on ctss_pkg and conv_tile_size_search_unit.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WatchdogLimit = 1500000;
  localparam int FaultNone = 0;
  localparam int FaultWeight = 1;
  localparam int FaultInput = 2;
  localparam int FaultOutput = 3;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [3:0] dilation;
    logic [3:0] stride;
    logic [3:0] kernel;
    logic [ctss_pkg::SpW-1:0] cols;
    logic [ctss_pkg::SpW-1:0] rows;
    logic [ctss_pkg::ChW-1:0] out_ch;
    logic [ctss_pkg::ChW-1:0] in_ch;
  } layer_t;

  typedef struct packed {
    logic [1:0] fit_status;
    logic [ctss_pkg::SpW-1:0] tile_cols;
    logic [ctss_pkg::SpW-1:0] tile_rows;
    logic [ctss_pkg::ChW-1:0] tile_out_ch;
  } tiles_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [ctss_pkg::LimW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ctss_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ctss_pkg::OutDataW-1:0] m_axis_tdata;

  logic [ctss_pkg::LimW-1:0] weight_lim, input_lim, output_lim;
  tiles_t pending_tiles[$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int unsigned quiet_cycles = 0;

  conv_tile_size_search_unit dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic longint unsigned clamp_field(longint unsigned v, longint unsigned maxv);
    if (v == 0) v = 1;
    if (v > maxv) v = maxv;
    return v;
  endfunction

  function automatic int depth_fault(longint unsigned n, m, tm, tr, tc, k, s, d);
    longint unsigned g_in, g_out, t, halo, gdepth, wdepth, odepth;
    g_in = (n + 31) / 32;
    g_out = 0;
    for (longint unsigned st = 0; st < m; st += tm) begin
      t = (st + tm + 15) / 16 - st / 16;
      if (t > g_out) g_out = t;
    end
    halo = (k - 1) * d + 1;
    gdepth = ((tr - 1) * s + halo) * ((tc - 1) * s + halo) * g_in;
    wdepth = g_in * k * k * g_out;
    odepth = tr * tc * g_out;
    if (wdepth >= weight_lim) return FaultWeight;
    if (gdepth >= input_lim) return FaultInput;
    if (odepth >= output_lim) return FaultOutput;
    return FaultNone;
  endfunction

  function automatic tiles_t predict_tiles(layer_t l);
    longint unsigned n, m, r, c, k, s, d, tm, tr, tc, prev;
    logic [1:0] st;
    int f;
    tiles_t res;
    n = clamp_field(l.in_ch, 4096);
    m = clamp_field(l.out_ch, 4096);
    r = clamp_field(l.rows, 1024);
    c = clamp_field(l.cols, 1024);
    k = clamp_field(l.kernel, 15);
    s = clamp_field(l.stride, 15);
    d = clamp_field(l.dilation, 15);
    tm = m; tr = r; tc = c;
    st = ctss_pkg::StFit;
    f = depth_fault(n, m, tm, tr, tc, k, s, d);
    while (f != FaultNone) begin
      if (f == FaultWeight) begin
        prev = tm;
        if (tm % 2 == 0) tm = tm / 2;
        else if (tm % 3 == 0) tm = tm / 3;
        else if (tm % 5 == 0) tm = tm / 5;
        else tm = 16;
        if (tm < 16) tm = 16;
        if (tm == prev) begin
          st = ctss_pkg::StWeight;
          break;
        end
      end else begin
        // spatial shrink: rows first, then columns
        if (tr != 1) tr = (tr % 2 == 0) ? tr / 2 : (tr % 3 == 0) ? tr / 3 : 1;
        else if (tc != 1) tc = (tc % 2 == 0) ? tc / 2 : (tc % 3 == 0) ? tc / 3 : 1;
        else begin
          st = ctss_pkg::StSpatial;
          break;
        end
        if (tm < 16) tm = 16;
      end
      f = depth_fault(n, m, tm, tr, tc, k, s, d);
    end
    if (st == ctss_pkg::StFit) begin
      for (longint unsigned sc = 2; sc * tr <= r; sc++)
        if (depth_fault(n, m, tm, sc * tr, tc, k, s, d) == FaultNone) tr = sc * tr;
    end
    res.tile_out_ch = tm[ctss_pkg::ChW-1:0];
    res.tile_rows = tr[ctss_pkg::SpW-1:0];
    res.tile_cols = tc[ctss_pkg::SpW-1:0];
    res.fit_status = st;
    return res;
  endfunction

  task automatic send_layer(layer_t l);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, l};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_tiles.push_back(predict_tiles(l));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limits(logic [ctss_pkg::LimW-1:0] wl, il, ol,
                              logic [ctss_pkg::LimW-1:0] junk);
    logic [1:0] idx[4];
    logic [ctss_pkg::LimW-1:0] val[4];
    idx = '{ctss_pkg::RegWeightLimit, ctss_pkg::RegInputLimit, ctss_pkg::RegOutputLimit,
            RegUnused};
    val = '{wl, il, ol, junk};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    weight_lim = wl;
    input_lim = il;
    output_lim = ol;
    @(posedge clk_i);
  endtask

  function automatic layer_t mk(int ic, oc, r, c, k, s, d);
    layer_t l;
    l.in_ch = 13'(ic); l.out_ch = 13'(oc); l.rows = 11'(r); l.cols = 11'(c);
    l.kernel = 4'(k); l.stride = 4'(s); l.dilation = 4'(d);
    return l;
  endfunction

  function automatic layer_t rand_layer;
    layer_t l;
    int sel;
    sel = $urandom_range(99);
    l.in_ch = (sel < 10) ? 13'($urandom_range(0, 8191)) : 13'($urandom_range(1, 512));
    l.out_ch = ($urandom_range(9) == 0) ? 13'($urandom_range(0, 8191))
                                        : 13'($urandom_range(1, 512));
    l.rows = 11'($urandom_range(1, 48));
    // a few full-range rows; keep output channels low so the enlarge walk stays short
    if (sel == 99) begin
      l.rows = 11'($urandom_range(0, 2047));
      l.out_ch = 13'($urandom_range(0, 256));
    end
    l.cols = ($urandom_range(9) == 0) ? 11'($urandom_range(0, 2047))
                                      : 11'($urandom_range(1, 64));
    l.kernel = 4'($urandom_range(0, 15));
    l.stride = 4'($urandom_range(0, 15));
    l.dilation = 4'($urandom_range(0, 15));
    return l;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    tiles_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[36:0];
      if (pending_tiles.size() == 0) begin
        $error("unexpected result transfer %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_tiles.pop_front();
        if (got.tile_out_ch !== want.tile_out_ch) begin
          $error("tile_out_ch: expected %0d, got %0d", want.tile_out_ch, got.tile_out_ch);
          mismatches++;
        end
        if (got.tile_rows !== want.tile_rows) begin
          $error("tile_rows: expected %0d, got %0d", want.tile_rows, got.tile_rows);
          mismatches++;
        end
        if (got.tile_cols !== want.tile_cols) begin
          $error("tile_cols: expected %0d, got %0d", want.tile_cols, got.tile_cols);
          mismatches++;
        end
        if (got.fit_status !== want.fit_status) begin
          $error("fit_status: expected %0d, got %0d", want.fit_status, got.fit_status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed;
    layer_t l[$];
    l = '{mk(0, 0, 0, 0, 0, 0, 0), mk(8191, 8191, 2047, 2047, 15, 15, 15),
          mk(4096, 4096, 1024, 1024, 15, 15, 15), mk(1, 5, 4, 4, 1, 1, 1),
          mk(1, 5, 64, 64, 1, 1, 1), mk(1, 16, 8, 8, 15, 1, 15),
          mk(4096, 64, 8, 8, 3, 1, 1), mk(32, 32, 64, 64, 3, 1, 1),
          mk(64, 96, 30, 30, 3, 2, 1), mk(64, 80, 27, 25, 5, 1, 2),
          mk(16, 4096, 16, 16, 1, 1, 1), mk(4097, 4097, 1025, 1025, 1, 1, 1),
          mk(256, 45, 14, 14, 3, 1, 1), mk(1, 1, 1, 1, 1, 1, 1)};
    foreach (l[i]) send_layer(l[i]);
    drain();
  endtask

  task automatic test_limit_extremes;
    write_limits(16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_layer(mk(32, 32, 8, 8, 3, 1, 1));
    send_layer(mk(1, 1, 1, 1, 1, 1, 1));
    drain();
    write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_layer(mk(32, 32, 8, 8, 3, 1, 1));
    send_layer(mk(512, 512, 48, 48, 3, 1, 1));
    drain();
    write_limits(16'hFFFF, 16'd1, 16'hFFFF, 16'h5A5A);
    send_layer(mk(1, 1, 1, 1, 1, 1, 1));
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        drain();
        case ($urandom_range(4))
          0: write_limits(ctss_pkg::WeightLimitRst, ctss_pkg::InputLimitRst,
                          ctss_pkg::OutputLimitRst, 16'($urandom));
          1: write_limits(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                          16'($urandom_range(1, 65535)), 16'($urandom));
          2: write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'($urandom));
          default: write_limits(16'($urandom_range(64, 4096)), 16'($urandom_range(256, 16384)),
                                16'($urandom_range(256, 16384)), 16'($urandom));
        endcase
        case ((i / 100) % 4)
          0: begin idle_pct = 0; stall_pct = 0; end
          1: begin idle_pct = 45; stall_pct = 0; end
          2: begin idle_pct = 0; stall_pct = 45; end
          default: begin idle_pct = 36; stall_pct = 36; end
        endcase
      end
      // occasionally hold off until the block has delivered everything
      if ($urandom_range(19) == 0) begin
        s_axis_tvalid <= 1'b0;
        while (pending_tiles.size() != 0) @(posedge clk_i);
      end
      send_layer(rand_layer());
    end
    drain();
  endtask

  initial begin
    weight_lim = ctss_pkg::WeightLimitRst;
    input_lim = ctss_pkg::InputLimitRst;
    output_lim = ctss_pkg::OutputLimitRst;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limit_extremes();
    test_random(1930);
    if (mismatches == 0 && pending_tiles.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* conv_tile_size_search_unit.f */
hdl/ctss_pkg.sv
hdl/conv_tile_size_search_unit.sv
bench/testbench.sv
